FILE: hw/rtl/dssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_pkg
// Shared codes and controller/datapath interface types for the dual stack.
// ----------------------------------------------------------------------------
package dssm_pkg;

	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;
	localparam int WORD_W   = 32;

	localparam logic [CMD_W-1:0] CMD_PUSH_ONE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_TWO = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_ONE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_TWO  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SHOW_ONE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SHOW_TWO = 3'd5;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // request taken this cycle
		logic rd_en;    // fetch next shown entry
	} dssm_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic cmd_valid;  // known command, gives a result
		logic show_go;    // show of a non-empty stack
		logic out_last;   // held result is the final one
	} dssm_sts_t;

endpackage

FILE: hw/rtl/dssm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_ctrl
// Sequencer: takes one request at a time, paces reads and result hand-off.
// ----------------------------------------------------------------------------
module dssm_ctrl import dssm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  dssm_sts_t sts,
	output dssm_ctl_t ctl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);

	always_comb begin
		state_d    = state_q;
		ctl.accept = 1'b0;
		ctl.rd_en  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ctl.accept = 1'b1;
					if (!sts.cmd_valid) begin
						state_d = ST_IDLE;
					end else if (sts.show_go) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_READ: begin
				ctl.rd_en = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (m_tready) begin
					if (sts.out_last) begin
						state_d = ST_IDLE;
					end else begin
						// fetch the next entry as this one leaves
						ctl.rd_en = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/dssm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_datapath
// Shared store, stack counts, show pointer and result register.
// ----------------------------------------------------------------------------
module dssm_datapath import dssm_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [CMD_W-1:0]           cmd,
	input  logic signed [WORD_W-1:0]   push_value,
	input  dssm_ctl_t                  ctl,
	output dssm_sts_t                  sts,
	output logic [STATUS_W-1:0]        status,
	output logic signed [WORD_W-1:0]   read_value,
	output logic                       last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [WORD_W-1:0] mem [DEPTH];

	logic [CW-1:0]       lower_q;
	logic [CW-1:0]       upper_q;
	logic [AW-1:0]       ptr_q;
	logic                dir_up_q;
	logic [CW-1:0]       remain_q;
	logic [STATUS_W-1:0] status_q;
	logic                last_q;
	logic                sel_mem_q;
	logic [WORD_W-1:0]   rd_data_q;

	logic          upper_sel;
	logic          is_push;
	logic          is_pop;
	logic          is_show;
	logic [CW-1:0] sel_count;
	logic          full;
	logic          empty;
	logic          do_write;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] up_push_pos;
	logic [CW-1:0] up_top_pos;
	logic [CW-1:0] lo_top_pos;

	assign upper_sel = cmd inside {CMD_PUSH_TWO, CMD_POP_TWO, CMD_SHOW_TWO};
	assign is_push   = cmd inside {CMD_PUSH_ONE, CMD_PUSH_TWO};
	assign is_pop    = cmd inside {CMD_POP_ONE, CMD_POP_TWO};
	assign is_show   = cmd inside {CMD_SHOW_ONE, CMD_SHOW_TWO};

	assign sel_count = upper_sel ? upper_q : lower_q;
	assign full      = ({1'b0, lower_q} + {1'b0, upper_q}) >= {1'b0, DEPTH_C};
	assign empty     = (sel_count == '0);

	assign up_push_pos = DEPTH_C - upper_q - CW'(1);
	assign up_top_pos  = DEPTH_C - upper_q;
	assign lo_top_pos  = lower_q - CW'(1);

	assign do_write = ctl.accept && is_push && !full;
	assign wr_addr  = upper_sel ? up_push_pos[AW-1:0] : lower_q[AW-1:0];

	assign sts.cmd_valid = is_push || is_pop || is_show;
	assign sts.show_go   = is_show && !empty;
	assign sts.out_last  = last_q;

	assign status     = status_q;
	assign last       = last_q;
	assign read_value = sel_mem_q ? $signed(rd_data_q) : '0;

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_addr] <= push_value;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
		end else if (ctl.accept) begin
			if (is_push && !full) begin
				if (upper_sel) begin
					upper_q <= upper_q + CW'(1);
				end else begin
					lower_q <= lower_q + CW'(1);
				end
			end else if (is_pop && !empty) begin
				if (upper_sel) begin
					upper_q <= upper_q - CW'(1);
				end else begin
					lower_q <= lower_q - CW'(1);
				end
			end
		end
	end

	// result register and show walk; payload only, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			last_q    <= 1'b1;
			sel_mem_q <= 1'b0;
			dir_up_q  <= upper_sel;
			remain_q  <= sel_count;
			ptr_q     <= upper_sel ? up_top_pos[AW-1:0] : lo_top_pos[AW-1:0];
			if (is_push) begin
				status_q <= full ? STATUS_FULL : STATUS_OK;
			end else begin
				status_q <= empty ? STATUS_EMPTY : STATUS_OK;
			end
		end else if (ctl.rd_en) begin
			// stack two walks upward from its top, stack one downward
			ptr_q     <= dir_up_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
			remain_q  <= remain_q - CW'(1);
			last_q    <= (remain_q == CW'(1));
			sel_mem_q <= 1'b1;
			status_q  <= STATUS_OK;
		end
	end

endmodule

FILE: hw/rtl/dual_stack_shared_memory_top.sv
`timescale 1ns / 1ps
// Push/pop: result valid in the cycle after the request; next request taken the cycle after
//   the result is taken.
// Show of n entries: first entry after the request and a read state, then one entry per cycle
//   while the sink is ready, paced by the registered read port of the store.
// Unknown commands are taken with no result.
// Reset clears both stack counts at once; store contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_top
// Two stacks growing towards each other in one shared store, stream interface.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_top import dssm_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] push_value
	input  logic [2:0]  s_tuser,   // [2:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] read_value
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	dssm_ctl_t ctl;
	dssm_sts_t sts;

	logic signed [WORD_W-1:0] read_value;

	dssm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	dssm_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (s_tuser),
		.push_value ($signed(s_tdata)),
		.ctl        (ctl),
		.sts        (sts),
		.status     (m_tuser),
		.read_value (read_value),
		.last       (m_tlast)
	);

	assign m_tdata = $unsigned(read_value);

endmodule
